[sv/pngt_pkg.sv]
// ----------------------------------------------------------------------------
// pngt_pkg
// Shared types and constants for the per-node sequence gap tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pngt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int ID_W    = 16;
  localparam int SEQ_W   = 16;
  localparam int GAP_W   = 15;
  localparam int SLOT_W  = 4;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET = GAP_W'(1000);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    ORIGIN_EXISTING = 2'd0,
    ORIGIN_FREE     = 2'd1,
    ORIGIN_REPLACE  = 2'd2
  } origin_t;

  typedef struct packed {
    logic [ID_W-1:0]  node_id;
    logic [SEQ_W-1:0] seq_number;
  } in_beat_t;

  typedef struct packed {
    logic             accepted;
    logic [GAP_W-1:0] lost_count;
    logic [SLOT_W-1:0] slot;
    origin_t          slot_origin;
  } out_beat_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] expect_seq;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             accepted;
    logic [GAP_W-1:0] lost;
    logic [SEQ_W-1:0] next_seq;
  } chk_res_t;

endpackage

`default_nettype wire

[sv/pngt_slot_table.sv]
// ----------------------------------------------------------------------------
// pngt_slot_table
// Node table memory with one registered read port, one write port and
// per-entry valid bits; an entry never written reads as free.
// ----------------------------------------------------------------------------
`default_nettype none

module pngt_slot_table
  import pngt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire tbl_wr_t          wr,
  output entry_t                rd_entry
);

  entry_t                   mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   rd_q_r;
  logic                     rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_q_r   <= mem_r[rd_addr];
    rd_vld_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // Mask entries never written back to the free state.
  assign rd_entry = rd_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

[sv/pngt_seq_check.sv]
// ----------------------------------------------------------------------------
// pngt_seq_check
// Sequence compare unit: wrapped difference, stale test and gap count.
// ----------------------------------------------------------------------------
`default_nettype none

module pngt_seq_check
  import pngt_pkg::*;
(
  input  wire logic [SEQ_W-1:0] expect_seq,
  input  wire logic [SEQ_W-1:0] seq,
  input  wire logic [GAP_W-1:0] max_gap,
  output chk_res_t              res
);

  logic [SEQ_W-1:0] diff;

  always_comb begin
    diff         = seq - expect_seq;
    res.accepted = 1'b1;
    res.lost     = '0;
    res.next_seq = seq + SEQ_W'(1);
    if (expect_seq != '0) begin
      if (diff[SEQ_W-1]) begin
        // Behind the expected number: drop as stale.
        res.accepted = 1'b0;
      end else if (diff != '0 && diff < {1'b0, max_gap}) begin
        res.lost = diff[GAP_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[sv/per_node_sequence_gap_tracker.sv]
// ----------------------------------------------------------------------------
// per_node_sequence_gap_tracker
// Tracks per-node sequence numbers in a small slot table and reports lost
// packets, stale packets and which slot served each node.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            beat
//   in_      input      in_valid / in_stall  in_beat_t  {node_id, seq_number}
//   out_     output     out_valid/ out_stall out_beat_t {accepted, lost_count,
//                                                         slot, slot_origin}
//   cfg_     input      cfg_valid/ cfg_ready 15-bit max_gap
//
// The block takes one packet at a time: the lookup walks the table one entry
// per cycle through its single read port, then an evaluate step judges the
// packet and writes back, and a push step hands off the result.
// A hit ends the walk at the matching slot.
// in_stall is high from the accept until the result enters the output
// register; a result still waiting there does not block the next accept.
// Reset (rst_n low, synchronous) frees every slot at once through the
// table's valid bits, zeroes the victim pointer and loads max_gap with 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module per_node_sequence_gap_tracker
  import pngt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,

  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_beat_t         in_data,

  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_beat_t             out_data,

  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [GAP_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_PUSH
  } state_t;

  state_t           state_r,     state_nxt;
  in_beat_t         in_r,        in_nxt;
  logic [CNT_W-1:0] iss_r,       iss_nxt;      // next table address to issue
  logic [IDX_W-1:0] cmp_r,       cmp_nxt;      // address whose data is back
  logic             pend_r,      pend_nxt;     // read data valid this cycle
  logic             free_r,      free_nxt;
  logic [IDX_W-1:0] free_idx_r,  free_idx_nxt;
  logic [IDX_W-1:0] slot_r,      slot_nxt;
  logic [SEQ_W-1:0] exp_r,       exp_nxt;
  origin_t          origin_r,    origin_nxt;
  logic [IDX_W-1:0] vp_r,        vp_nxt;
  logic [GAP_W-1:0] max_gap_r,   max_gap_nxt;
  out_beat_t        res_r,       res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_beat_r,  out_beat_nxt;

  entry_t   rd_entry;
  tbl_wr_t  tbl_wr;
  chk_res_t chk;
  logic     hit;
  logic     free_now;
  logic     last;

  pngt_slot_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (iss_r[IDX_W-1:0]),
    .wr       (tbl_wr),
    .rd_entry (rd_entry)
  );

  pngt_seq_check u_check (
    .expect_seq (exp_r),
    .seq        (in_r.seq_number),
    .max_gap    (max_gap_r),
    .res        (chk)
  );

  // Compare the entry that came back from the previous read.
  assign hit      = pend_r && (rd_entry.id == in_r.node_id);
  assign free_now = pend_r && (rd_entry.id == '0) && !free_r;
  assign last     = pend_r && (cmp_r == LAST_IDX);

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    pend_nxt      = pend_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    slot_nxt      = slot_r;
    exp_nxt       = exp_r;
    origin_nxt    = origin_r;
    vp_nxt        = vp_r;
    max_gap_nxt   = max_gap_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    tbl_wr        = '0;

    if (cfg_valid) begin
      max_gap_nxt = cfg_data;
    end

    // Retire the output beat once the sink takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          iss_nxt   = '0;
          pend_nxt  = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous one is compared.
        if (iss_r < CNT_W'(TABLE_ENTRIES)) begin
          iss_nxt  = iss_r + CNT_W'(1);
          cmp_nxt  = iss_r[IDX_W-1:0];
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end

        if (hit) begin
          slot_nxt   = cmp_r;
          exp_nxt    = rd_entry.expect_seq;
          origin_nxt = ORIGIN_EXISTING;
          state_nxt  = ST_EVAL;
        end else begin
          if (free_now) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_r;
          end
          if (last) begin
            // Unknown node: claim the first free slot or the victim.
            exp_nxt = '0;
            if (free_r) begin
              slot_nxt   = free_idx_r;
              origin_nxt = ORIGIN_FREE;
            end else if (free_now) begin
              slot_nxt   = cmp_r;
              origin_nxt = ORIGIN_FREE;
            end else begin
              slot_nxt   = vp_r;
              origin_nxt = ORIGIN_REPLACE;
            end
            state_nxt = ST_EVAL;
          end
        end
      end

      ST_EVAL: begin
        // A claim always writes the slot; a stale packet leaves it alone.
        tbl_wr.en              = (origin_r != ORIGIN_EXISTING) || chk.accepted;
        tbl_wr.addr            = slot_r;
        tbl_wr.data.id         = in_r.node_id;
        tbl_wr.data.expect_seq = chk.accepted ? chk.next_seq : '0;
        if (origin_r == ORIGIN_REPLACE) begin
          vp_nxt = (vp_r == LAST_IDX) ? '0 : vp_r + IDX_W'(1);
        end
        res_nxt.accepted    = chk.accepted;
        res_nxt.lost_count  = chk.lost;
        res_nxt.slot        = SLOT_W'(slot_r);
        res_nxt.slot_origin = origin_r;
        state_nxt           = ST_PUSH;
      end

      ST_PUSH: begin
        // Hold until the output register is free or being emptied.
        if (!out_valid_r || !out_stall) begin
          out_beat_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    iss_r      <= iss_nxt;
    cmp_r      <= cmp_nxt;
    free_idx_r <= free_idx_nxt;
    slot_r     <= slot_nxt;
    exp_r      <= exp_nxt;
    origin_r   <= origin_nxt;
    res_r      <= res_nxt;
    out_beat_r <= out_beat_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      free_r      <= 1'b0;
      vp_r        <= '0;
      max_gap_r   <= MAX_GAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      free_r      <= free_nxt;
      vp_r        <= vp_nxt;
      max_gap_r   <= max_gap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;
  assign cfg_ready = 1'b1;

  // Table writes come only from the evaluate step.
  a_wr_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> (state_r == ST_EVAL))
    else $error("table write outside evaluate step");

  // A stale packet never reports lost packets.
  a_stale_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_beat_r.accepted) |-> (out_beat_r.lost_count == '0))
    else $error("stale packet with nonzero lost count");

  // A replacement advances the victim pointer by exactly one, wrapping.
  a_victim_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && origin_r == ORIGIN_REPLACE) |=>
      (vp_r == (($past(vp_r) == LAST_IDX) ? '0 : $past(vp_r) + IDX_W'(1))))
    else $error("victim pointer did not advance on replacement");

  // Outside a replacement the victim pointer holds.
  a_victim_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_EVAL && origin_r == ORIGIN_REPLACE) |=> $stable(vp_r))
    else $error("victim pointer moved without replacement");

endmodule

`default_nettype wire

[tb/per_node_sequence_gap_tracker_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_node_sequence_gap_tracker_test
// Drives node/sequence packets into the gap tracker under random idling on
// both channels, predicts every verdict with a local slot table model and
// compares each output beat field by field, in order.
// ----------------------------------------------------------------------------

module per_node_sequence_gap_tracker_test;
  import pngt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT ports
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [GAP_W-1:0] cfg_data;

  per_node_sequence_gap_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Local copy of the slot table, victim pointer and max_gap setting
  logic [ID_W-1:0]  node_tag [TABLE_ENTRIES];
  logic [SEQ_W-1:0] next_seq [TABLE_ENTRIES];
  logic [IDX_W-1:0] victim;
  logic [GAP_W-1:0] gap_limit;

  // Verdicts predicted at input accept, waiting for their output beat
  out_beat_t expected_verdicts[$];

  // Stimulus bookkeeping: last forward sequence number sent per node
  logic [SEQ_W-1:0] seq_cursor [logic [ID_W-1:0]];
  logic [ID_W-1:0]  node_pool[$];

  // Set to suppress all idling on both channels
  bit steady_flow = 1'b0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // --------------------------------------------------------------------------
  // Predictor: look up or claim a slot, then judge the sequence number.
  // Updates the local table exactly as the block would on this packet.
  // --------------------------------------------------------------------------
  function automatic out_beat_t classify_packet(in_beat_t pkt);
    out_beat_t        verdict;
    int               hit;
    int               free_at;
    int               pick;
    logic [SEQ_W-1:0] diff;
    hit     = -1;
    free_at = -1;
    verdict = '0;
    verdict.accepted = 1'b1;
    // The first matching id wins, so an id of zero matches the first free slot.
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && node_tag[i] == pkt.node_id) hit = i;
      if (free_at < 0 && node_tag[i] == '0) free_at = i;
    end
    if (hit >= 0) begin
      pick = hit;
      verdict.slot_origin = ORIGIN_EXISTING;
    end else begin
      if (free_at >= 0) begin
        pick = free_at;
        verdict.slot_origin = ORIGIN_FREE;
      end else begin
        // Table full: evict the victim and advance the round-robin pointer
        pick = int'(victim);
        victim = (victim == LAST_IDX) ? '0 : victim + 1'b1;
        verdict.slot_origin = ORIGIN_REPLACE;
      end
      node_tag[pick] = pkt.node_id;
      next_seq[pick] = '0;
    end
    // Expected number zero means unseen: accept without comparing
    if (next_seq[pick] != '0) begin
      diff = pkt.seq_number - next_seq[pick];
      if (diff[SEQ_W-1]) begin
        verdict.accepted = 1'b0;
      end else if (diff != '0 && diff < gap_limit) begin
        verdict.lost_count = diff[GAP_W-1:0];
      end
    end
    if (verdict.accepted) next_seq[pick] = pkt.seq_number + 1'b1;
    verdict.slot = SLOT_W'(pick);
    return verdict;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Beat monitor: sample both channels at the rising edge. Check the output
  // beat against the oldest prediction, then predict the accepted input beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_beats
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: %h", out_data));
      end else begin
        want = expected_verdicts.pop_front();
        if (out_data.accepted !== want.accepted)
          report_mismatch($sformatf("accepted got %0d want %0d",
                                    out_data.accepted, want.accepted));
        if (out_data.lost_count !== want.lost_count)
          report_mismatch($sformatf("lost_count got %0d want %0d",
                                    out_data.lost_count, want.lost_count));
        if (out_data.slot !== want.slot)
          report_mismatch($sformatf("slot got %0d want %0d",
                                    out_data.slot, want.slot));
        if (out_data.slot_origin !== want.slot_origin)
          report_mismatch($sformatf("slot_origin got %0d want %0d",
                                    out_data.slot_origin, want.slot_origin));
      end
    end
    if (rst_n && in_valid && !in_stall)
      expected_verdicts = {expected_verdicts, classify_packet(in_data)};
  end

  // Random backpressure on the result channel, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < 31);
  end

  // Watchdog: end the run if the traffic hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Send one packet. Call at a falling edge; returns at the falling edge after
  // the accept with valid still high, so back-to-back beats need no gap.
  // --------------------------------------------------------------------------
  task automatic send_packet(input logic [ID_W-1:0] id, input logic [SEQ_W-1:0] seq);
    // Idle a random number of cycles before presenting the beat
    while (!steady_flow && $urandom_range(99) < 31) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{node_id: id, seq_number: seq};
    // Hold the beat until the block takes it
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Write max_gap once every outstanding verdict has come back
  task automatic write_max_gap(input logic [GAP_W-1:0] value);
    in_valid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    gap_limit = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Gap, stale, large-jump and unseen rules on a couple of nodes; max_gap is
  // still at its reset value of 1000 here.
  task automatic test_gap_rules();
    send_packet(16'h0001, 16'h0000);   // claim free slot, unseen
    send_packet(16'h0001, 16'h0005);   // four lost
    send_packet(16'h0001, 16'd1005);   // 999 lost, just under the limit
    send_packet(16'h0001, 16'd2006);   // jump of exactly max_gap: silent
    send_packet(16'h0001, 16'h87D7);   // difference 0x8000: stale
    send_packet(16'h0001, 16'd2006);   // repeat of last packet: stale
    send_packet(16'h0001, 16'd2007);   // in order again
    send_packet(16'hFFFF, 16'hFFFF);   // expected wraps to zero
    send_packet(16'hFFFF, 16'h1234);   // unseen after wrap: no compare
    send_packet(16'h0000, 16'h8000);   // id zero matches the first free slot
  endtask

  // Fill the table, then force replacements, including one by id zero
  task automatic test_slot_allocation();
    for (int i = 2; i < TABLE_ENTRIES; i++)
      send_packet(16'h0100 + i[ID_W-1:0], i[SEQ_W-1:0]);
    send_packet(16'hABCD, 16'd7);      // table full: evict slot 0
    send_packet(16'h0000, 16'd0);      // evict slot 1, which reads as free
    send_packet(16'h5555, 16'd1);      // claim the slot just freed
  endtask

  // Widest and narrowest max_gap settings, on node 0xABCD (expects 8)
  task automatic test_max_gap_extremes();
    write_max_gap(15'h7FFF);
    send_packet(16'hABCD, 16'd32774);  // largest lost count, 32766
    write_max_gap(15'd0);
    send_packet(16'hABCD, 16'd32780);  // zero limit: never counted
    write_max_gap(15'd1);
    send_packet(16'hABCD, 16'd32782);  // gap of one is not below one
  endtask

  // Mostly in-order traffic from a pool of nodes with random gaps, stale
  // repeats, large jumps and wraps; pools wider than the table thrash slots.
  task automatic run_traffic(input int count, input int pool_size);
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] ahead;
    int               roll;
    node_pool = {};
    repeat (pool_size) node_pool = {node_pool, ID_W'($urandom_range(1, 65535))};
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 85)      id = node_pool[$urandom_range(pool_size - 1)];
      else if (roll < 90) id = '0;
      else                id = ID_W'($urandom);
      base = seq_cursor.exists(id) ? seq_cursor[id] : SEQ_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 50)      seq = base + 1'b1;
      else if (roll < 65) seq = base + 1'b1 + SEQ_W'($urandom_range(1, 40));
      else if (roll < 75) seq = base - SEQ_W'($urandom_range(0, 60));
      else if (roll < 83) seq = base + SEQ_W'($urandom_range(1000, 32767));
      else if (roll < 88) seq = base + 16'h8000;
      else if (roll < 93) seq = 16'hFFFF - SEQ_W'($urandom_range(0, 3));
      else                seq = SEQ_W'($urandom);
      // Advance the cursor only on forward moves
      ahead = seq - base;
      if (!ahead[SEQ_W-1]) seq_cursor[id] = seq;
      send_packet(id, seq);
    end
  endtask

  task automatic test_random_traffic();
    write_max_gap(MAX_GAP_RESET);
    run_traffic(170, 10);
    write_max_gap(15'h7FFF);
    run_traffic(150, 24);
    write_max_gap(15'd1);
    run_traffic(80, 14);
    write_max_gap(15'd0);
    run_traffic(60, 18);
    // Long stretch with no idling on either side
    write_max_gap(GAP_W'($urandom));
    steady_flow = 1'b1;
    run_traffic(100, 12);
    steady_flow = 1'b0;
    write_max_gap(GAP_W'($urandom_range(2, 64)));
    run_traffic(90, 20);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      node_tag[i] = '0;
      next_seq[i] = '0;
    end
    victim    = '0;
    gap_limit = MAX_GAP_RESET;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_gap_rules();
    test_slot_allocation();
    test_max_gap_extremes();
    test_random_traffic();

    // Drain: wait for every verdict, then watch for stray beats a while
    in_valid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (TABLE_ENTRIES + 8) @(negedge clk);

    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pngt_pkg.sv
sv/pngt_slot_table.sv
sv/pngt_seq_check.sv
sv/per_node_sequence_gap_tracker.sv
tb/per_node_sequence_gap_tracker_test.sv
